// ===== src/postfix_modular_stack_evaluator_macros.svh =====
// Assertion helpers shared by the evaluator modules.
`ifndef POSTFIX_MODULAR_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_MODULAR_STACK_EVALUATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pmse_pkg.sv =====
package pmse_pkg;

	localparam int unsigned VAL_W           = 30;
	localparam int unsigned MODE_W          = 2;
	localparam int unsigned IN_DATA_W       = ((VAL_W + 7) / 8) * 8;
	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned MUL_STEPS       = 3;
	localparam int unsigned MUL_CNT_W       = $clog2(MUL_STEPS);

	localparam logic [VAL_W-1:0] MOD_P = VAL_W'(1000000007);

	// floor(2^60 / P), the reciprocal that gives the quotient estimate of the
	// modular multiplier.
	localparam logic [63:0]    BARRETT_MU_WIDE = (64'd1 << (2 * VAL_W)) / {34'd0, MOD_P};
	localparam logic [VAL_W:0] BARRETT_MU      = BARRETT_MU_WIDE[VAL_W:0];

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH = 2'd0,
		MODE_ADD  = 2'd1,
		MODE_SUB  = 2'd2,
		MODE_MUL  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL
	} state_t;

endpackage

// ===== src/pmse_ram.sv =====
module pmse_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pmse_mulmod.sv =====
`include "postfix_modular_stack_evaluator_macros.svh"

module pmse_mulmod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pmse_pkg::VAL_W-1:0] op_a,
	input  logic [pmse_pkg::VAL_W-1:0] op_b,
	output logic                       busy,
	output logic [pmse_pkg::VAL_W-1:0] result
);

	import pmse_pkg::*;

	localparam int unsigned PROD_W = 2 * VAL_W;
	localparam int unsigned MU_W   = VAL_W + 1;
	localparam int unsigned EST_W  = 2 * MU_W;
	localparam int unsigned REM_W  = VAL_W + 2;

	logic                 busy_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    prod_s1;
	logic [EST_W-1:0]     est_s2;
	logic [REM_W-1:0]     rem_s3;
	logic [VAL_W-1:0]     acc_q;

	logic [REM_W-1:0] rem_m1;
	logic [REM_W-1:0] rem_m2;
	logic [VAL_W-1:0] rem_red;

	// Barrett reduction: the quotient estimate from the upper product bits is
	// at most two short, so the remainder stays below 3P and fits in 32 bits.
	always_comb begin
		rem_m1 = rem_s3 - {2'b00, MOD_P};
		rem_m2 = rem_s3 - {1'b0, MOD_P, 1'b0};
		if (rem_s3 >= {1'b0, MOD_P, 1'b0}) begin
			rem_red = rem_m2[VAL_W-1:0];
		end else if (rem_s3 >= {2'b00, MOD_P}) begin
			rem_red = rem_m1[VAL_W-1:0];
		end else begin
			rem_red = rem_s3[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + MUL_CNT_W'(1);
			if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The product loads at start and the later stages advance while busy; after
	// the last busy cycle each one holds the value derived from the product taken at start.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
		end
		if (busy_q) begin
			est_s2 <= EST_W'(prod_s1[PROD_W-1:VAL_W-1]) * EST_W'(BARRETT_MU);
			rem_s3 <= prod_s1[REM_W-1:0] - REM_W'(est_s2[EST_W-1:MU_W]) * REM_W'(MOD_P);
			acc_q  <= rem_red;
		end
	end

	assign busy   = busy_q;
	assign result = acc_q;

	`PMSE_ASSERT_IMPL(a_start_idle, clk, arst_n, start, !busy_q,
		"multiplier started while busy")
	`PMSE_ASSERT_IMPL(a_res_reduced, clk, arst_n, $fell(busy_q), acc_q < MOD_P,
		"product not reduced below the modulus")
	`PMSE_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q,
		"multiplier did not go busy after start")

endmodule

// ===== src/postfix_modular_stack_evaluator.sv =====
// Postfix evaluator modulo 1000000007 with a stack held in a synchronous RAM.
// Input transfer (s_*): s_tuser carries the token kind (push, add, subtract,
// multiply) and s_tdata the literal, used only by a push and reduced below
// the modulus on entry. Output transfer (m_*): one result per token with the
// new top of stack, the depth and the underflow / overflow flags of that token.
// The top entry is cached in a register; the second operand is read from the
// RAM when the token is taken and held in the RAM read register until used.
// Push, add and subtract raise the output valid from the EXEC state once the
// output register is free; the next token is taken after that, in IDLE.
// Multiply passes from EXEC to the MUL state: the 30 x 30 product is formed
// as the multiplier starts, a Barrett reduction by a constant reciprocal
// then forms the quotient estimate, the remainder and the corrected result,
// and the output register loads once the multiplier is no longer busy.
// One token is in work at a time; the next one is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// If the receiver stalls with a result still held, the next token waits in
// its final cycle until the output register frees.
// Reset empties the stack (depth 0) and drops any pending result; the RAM
// content is not cleared, since only entries below the depth are ever read.
module postfix_modular_stack_evaluator #(
	parameter int unsigned STACK_DEPTH = pmse_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [29:0] literal
	input  logic [pmse_pkg::IN_DATA_W-1:0]    s_tdata,
	// [1:0] mode
	input  logic [pmse_pkg::MODE_W-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// top_value, stack_depth, underflow, overflow (lowest first), zero padded
	output logic [((pmse_pkg::VAL_W + $clog2(STACK_DEPTH + 1) + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

	import pmse_pkg::*;

	localparam int unsigned CNT_W      = $clog2(STACK_DEPTH + 1);
	localparam int unsigned ADDR_W     = $clog2(STACK_DEPTH);
	localparam int unsigned OUT_W      = VAL_W + CNT_W + 2;
	localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

	state_t           state_q, state_d;
	mode_t            mode_q;
	logic [VAL_W-1:0] lit_q;
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] tos_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_top_q;
	logic [CNT_W-1:0] out_depth_q;
	logic             out_under_q;
	logic             out_over_q;

	logic             accept;
	logic             out_free;
	logic             finish;
	logic             mul_start;
	logic             mul_busy;
	logic [VAL_W-1:0] mul_res;

	logic [ADDR_W-1:0] rd_addr;
	logic [VAL_W-1:0]  rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [VAL_W-1:0]  res_val;
	logic [CNT_W-1:0]  count_d;
	logic              under_d;
	logic              over_d;

	logic [CNT_W-1:0] count_m1;
	logic [CNT_W-1:0] count_m2;
	logic             has_two;
	logic [VAL_W-1:0] op_a;
	logic [VAL_W-1:0] op_b;
	logic [VAL_W-1:0] lit_red;
	logic [VAL_W:0]   sum;
	logic [VAL_W:0]   sum_m;
	logic [VAL_W:0]   diff;
	logic [VAL_W-1:0] sum_red;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign count_m1 = count_q - CNT_W'(1);
	assign count_m2 = count_q - CNT_W'(2);
	assign has_two  = count_q >= CNT_W'(2);
	assign rd_addr  = count_m2[ADDR_W-1:0];

	// Operands: right one is the cached top, left one comes from the RAM.
	assign op_a = (count_q != '0) ? tos_q : '0;
	assign op_b = has_two ? rd_data : '0;

	always_comb begin
		lit_red = (lit_q >= MOD_P) ? (lit_q - MOD_P) : lit_q;
		sum     = {1'b0, op_a} + {1'b0, op_b};
		sum_m   = sum - {1'b0, MOD_P};
		sum_red = (sum >= {1'b0, MOD_P}) ? sum_m[VAL_W-1:0] : sum[VAL_W-1:0];
		if (op_b >= op_a) begin
			diff = {1'b0, op_b} - {1'b0, op_a};
		end else begin
			diff = {1'b0, op_b} + {1'b0, MOD_P} - {1'b0, op_a};
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (mode_q == MODE_MUL) begin
					state_d = ST_MUL;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				if (!mul_busy && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready  = 1'b0;
		mul_start = 1'b0;
		finish    = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EXEC: begin
				mul_start = (mode_q == MODE_MUL);
				finish    = (mode_q != MODE_MUL) && out_free;
			end
			ST_MUL:  finish = !mul_busy && out_free;
			default: ;
		endcase
	end

	// Stack update for the finishing token.
	always_comb begin
		case (mode_q)
			MODE_ADD: res_val = sum_red;
			MODE_SUB: res_val = diff[VAL_W-1:0];
			MODE_MUL: res_val = mul_res;
			default:  res_val = lit_red;
		endcase
		wr_en   = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		count_d = count_q;
		under_d = 1'b0;
		over_d  = 1'b0;
		if (mode_q == MODE_PUSH) begin
			if (count_q == CNT_W'(STACK_DEPTH)) begin
				over_d = 1'b1;
			end else begin
				wr_en   = finish;
				count_d = count_q + CNT_W'(1);
			end
		end else begin
			wr_en   = finish;
			wr_addr = has_two ? count_m2[ADDR_W-1:0] : '0;
			count_d = has_two ? count_m1 : CNT_W'(1);
			under_d = !has_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_PUSH;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q <= mode_t'(s_tuser);
			end
			if (finish) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lit_q <= s_tdata[VAL_W-1:0];
		end
		if (finish) begin
			if (!over_d) begin
				tos_q     <= res_val;
				out_top_q <= res_val;
			end else begin
				out_top_q <= tos_q;
			end
			out_depth_q <= count_d;
			out_under_q <= under_d;
			out_over_q  <= over_d;
		end
	end

	pmse_ram #(
		.WIDTH(VAL_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (res_val),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	pmse_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (op_a),
		.op_b   (op_b),
		.busy   (mul_busy),
		.result (mul_res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - OUT_W){1'b0}}, out_over_q, out_under_q,
		out_depth_q, out_top_q};

	`PMSE_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(STACK_DEPTH),
		"stack depth beyond capacity")
	`PMSE_ASSERT_IMPL(a_result_nonempty, clk, arst_n, out_valid_q, out_depth_q != '0,
		"result reports an empty stack")
	`PMSE_ASSERT_IMPL(a_flags_exclusive, clk, arst_n, out_valid_q,
		!(out_under_q && out_over_q), "underflow and overflow on one token")
	`PMSE_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == ST_EXEC,
		"accepted token did not start execution")

endmodule
